// ----- hdl/vgpl_pkg.sv -----
// Shared constants for the voxel grid point locator.
`timescale 1ns / 1ps

package vgpl_pkg;

  // Default geometry.
  localparam int INDEX_BITS_DEF = 12;
  localparam int COORD_BITS_DEF = 32;

  // Configuration port: one 64-bit register every 8 bytes.
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 6;
  localparam int REG_ADDR_LSB = 3;
  localparam int REG_IDX_W    = CFG_ADDR_W - REG_ADDR_LSB;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CELL_X   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CELL_Y   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CELL_Z   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_COUNTS   = 3'd6;

  // Cell edge after reset: 1.0 in Q16.16.
  localparam logic [CFG_DATA_W-1:0] CELL_ONE = 64'd65536;

  // Operation codes.
  localparam logic FUNC_LOCATE = 1'b0;
  localparam logic FUNC_CENTER = 1'b1;

endpackage

// ----- hdl/vgpl_div_stage.sv -----
// One restoring-division step: produces one quotient bit per cycle while en is high.
`timescale 1ns / 1ps

module vgpl_div_stage import vgpl_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int SHIFT      = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COORD_BITS-2:0] cell_len,
  input  logic [COORD_BITS-1:0] rem_in,
  input  logic [INDEX_BITS:0]   q_in,
  output logic [COORD_BITS-1:0] rem_out,
  output logic [INDEX_BITS:0]   q_out
);

  localparam int DW = COORD_BITS + INDEX_BITS;

  logic [DW-1:0]         dvs;
  logic [DW-1:0]         rem_ext;
  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  logic [INDEX_BITS:0]   q_r, q_nxt;

  always_comb begin
    dvs     = DW'(cell_len) << SHIFT;
    rem_ext = DW'(rem_in);
    rem_nxt = rem_in;
    q_nxt   = q_in;
    if (rem_ext >= dvs) begin
      rem_nxt = COORD_BITS'(rem_ext - dvs);
      q_nxt   = q_in | ((INDEX_BITS + 1)'(1) << SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign rem_out = rem_r;
  assign q_out   = q_r;

endmodule

// ----- hdl/vgpl_lane.sv -----
// One axis lane: range check, pipelined index division, cell center.
`timescale 1ns / 1ps

module vgpl_lane import vgpl_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic [INDEX_BITS+2:0]        en,
  input  logic signed [COORD_BITS-1:0] point,
  input  logic [INDEX_BITS-1:0]        index,
  input  logic [COORD_BITS-1:0]        origin,
  input  logic [COORD_BITS-2:0]        cell_len,
  input  logic [INDEX_BITS-1:0]        last,
  output logic                         in_range,
  output logic [INDEX_BITS-1:0]        found,
  output logic [COORD_BITS-1:0]        center
);

  localparam int N      = INDEX_BITS + 1;
  localparam int EXT_W  = COORD_BITS + INDEX_BITS;
  localparam int PROD_W = COORD_BITS + INDEX_BITS - 1;
  localparam int SUM_W  = COORD_BITS + INDEX_BITS + 2;

  // Axis extent (count * cell), follows the config registers.
  logic [EXT_W-1:0] extent_r, extent_nxt;
  logic [N-1:0]     count;

  always_comb begin
    count      = {1'b0, last} + N'(1);
    extent_nxt = EXT_W'(count) * EXT_W'(cell_len);
  end

  always_ff @(posedge clk) extent_r <= extent_nxt;

  // Stage 0: offset from origin.
  logic [COORD_BITS:0]     diff;
  logic                    below0_r;
  logic [COORD_BITS-1:0]   off0_r;
  logic [INDEX_BITS-1:0]   idx0_r;

  assign diff = {point[COORD_BITS-1], point} - {origin[COORD_BITS-1], origin};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      below0_r <= diff[COORD_BITS];
      off0_r   <= diff[COORD_BITS-1:0];
      idx0_r   <= index;
    end
  end

  // Stage 1: top-edge check and index * cell.
  logic                  out1_r;
  logic [PROD_W-1:0]     prod1_r;
  logic [COORD_BITS-1:0] off1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      out1_r  <= below0_r || (EXT_W'(off0_r) > extent_r);
      prod1_r <= PROD_W'(idx0_r) * PROD_W'(cell_len);
      off1_r  <= off0_r;
    end
  end

  // Center sum with saturation, done alongside the first division step.
  logic signed [SUM_W-1:0] sum;
  logic                    fits;
  logic [COORD_BITS-1:0]   sat;

  always_comb begin
    sum  = SUM_W'($signed(origin)) + SUM_W'(prod1_r) + SUM_W'(cell_len >> 1);
    fits = (&sum[SUM_W-1:COORD_BITS-1]) | ~(|sum[SUM_W-1:COORD_BITS-1]);
    if (fits)
      sat = sum[COORD_BITS-1:0];
    else if (sum[SUM_W-1])
      sat = {1'b1, {(COORD_BITS-1){1'b0}}};
    else
      sat = {1'b0, {(COORD_BITS-1){1'b1}}};
  end

  // Division stages, MSB of the quotient first.
  logic [COORD_BITS-1:0] rem_a [0:N];
  logic [N-1:0]          q_a   [0:N];
  logic                  out_r    [0:N-1];
  logic [COORD_BITS-1:0] center_r [0:N-1];

  assign rem_a[0] = off1_r;
  assign q_a[0]   = '0;

  for (genvar k = 0; k < N; k++) begin : g_div
    vgpl_div_stage #(
      .COORD_BITS(COORD_BITS),
      .INDEX_BITS(INDEX_BITS),
      .SHIFT     (N - 1 - k)
    ) u_stage (
      .clk     (clk),
      .en      (en[2+k]),
      .cell_len(cell_len),
      .rem_in  (rem_a[k]),
      .q_in    (q_a[k]),
      .rem_out (rem_a[k+1]),
      .q_out   (q_a[k+1])
    );

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[2]) begin
          out_r[0]    <= out1_r;
          center_r[0] <= sat;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[2+k]) begin
          out_r[k]    <= out_r[k-1];
          center_r[k] <= center_r[k-1];
        end
      end
    end
  end

  // Quotient clamp; zero-length cells only admit the origin itself.
  always_comb begin
    if (cell_len == '0)
      found = '0;
    else if (q_a[N] > {1'b0, last})
      found = last;
    else
      found = q_a[N][INDEX_BITS-1:0];
  end

  assign in_range = ~out_r[N-1];
  assign center   = center_r[N-1];

endmodule

// ----- hdl/vgpl_merge.sv -----
// Merge stage: combines the three lanes and registers the result.
`timescale 1ns / 1ps

module vgpl_merge import vgpl_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic                  func,
  input  logic                  inside_x,
  input  logic                  inside_y,
  input  logic                  inside_z,
  input  logic [INDEX_BITS-1:0] found_x,
  input  logic [INDEX_BITS-1:0] found_y,
  input  logic [INDEX_BITS-1:0] found_z,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-1:0] center_z,
  output logic                  inside_res,
  output logic [INDEX_BITS-1:0] res_x,
  output logic [INDEX_BITS-1:0] res_y,
  output logic [INDEX_BITS-1:0] res_z,
  output logic [COORD_BITS-1:0] ctr_x,
  output logic [COORD_BITS-1:0] ctr_y,
  output logic [COORD_BITS-1:0] ctr_z
);

  logic                  all_in;
  logic                  is_ctr;
  logic                  inside_r;
  logic [INDEX_BITS-1:0] res_x_r, res_y_r, res_z_r;
  logic [COORD_BITS-1:0] ctr_x_r, ctr_y_r, ctr_z_r;

  assign all_in = (func == FUNC_LOCATE) & inside_x & inside_y & inside_z;
  assign is_ctr = (func == FUNC_CENTER);

  always_ff @(posedge clk) begin
    if (load) begin
      inside_r <= all_in;
      res_x_r  <= all_in ? found_x : '0;
      res_y_r  <= all_in ? found_y : '0;
      res_z_r  <= all_in ? found_z : '0;
      ctr_x_r  <= is_ctr ? center_x : '0;
      ctr_y_r  <= is_ctr ? center_y : '0;
      ctr_z_r  <= is_ctr ? center_z : '0;
    end
  end

  assign inside_res = inside_r;
  assign res_x      = res_x_r;
  assign res_y      = res_y_r;
  assign res_z      = res_z_r;
  assign ctr_x      = ctr_x_r;
  assign ctr_y      = ctr_y_r;
  assign ctr_z      = ctr_z_r;

endmodule

// ----- hdl/voxel_grid_point_locate.sv -----
// Top level: uniform voxel grid locator with config registers and pipeline control.
//
// Usage
// - Input channel (in_*): one transaction per query. in_func = locate takes the
//   point fields, in_func = center takes the index fields; unused fields are
//   don't-care. Accepted on a clock edge with in_valid high and in_stall low.
// - Output channel (out_*): exactly one result transaction per query, in order.
// - Config port: APB-style, 64-bit data, register i at byte address 8*i; pready
//   is tied high. Change registers only while no query is in flight.
// - Pipeline: an offset stage, a range-check/multiply stage, INDEX_BITS + 1
//   division steps (one quotient bit per step), then the merge register.
// - Throughput: one query per cycle unless the output stalls; each lane's
//   divider is fully pipelined.
// - Stall: each stage holds while its successor is full and stalled, so
//   empty stages keep filling; in_stall rises only once the whole pipe is
//   full behind a stalled output.
// - Reset (synchronous, rst_n low): pipeline emptied, origins and counts
//   cleared, cell edges set to 1.0.
`timescale 1ns / 1ps

module voxel_grid_point_locate import vgpl_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  input  logic [INDEX_BITS-1:0]        in_index_x,
  input  logic [INDEX_BITS-1:0]        in_index_y,
  input  logic [INDEX_BITS-1:0]        in_index_z,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_inside_res,
  output logic [INDEX_BITS-1:0]        out_found_x,
  output logic [INDEX_BITS-1:0]        out_found_y,
  output logic [INDEX_BITS-1:0]        out_found_z,
  output logic signed [COORD_BITS-1:0] out_center_x,
  output logic signed [COORD_BITS-1:0] out_center_y,
  output logic signed [COORD_BITS-1:0] out_center_z,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready
);

  localparam int NST      = INDEX_BITS + 3;   // lane stages before merge
  localparam int CELL_W   = COORD_BITS - 1;
  localparam int COUNTS_W = 3 * INDEX_BITS;

  // ---------------- configuration registers ----------------
  logic [COORD_BITS-1:0] origin_x_r, origin_y_r, origin_z_r;
  logic [CELL_W-1:0]     cell_x_r, cell_y_r, cell_z_r;
  logic [COUNTS_W-1:0]   counts_r;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:REG_ADDR_LSB];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      cell_x_r   <= CELL_W'(CELL_ONE);
      cell_y_r   <= CELL_W'(CELL_ONE);
      cell_z_r   <= CELL_W'(CELL_ONE);
      counts_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ORIGIN_X: origin_x_r <= pwdata[COORD_BITS-1:0];
        REG_ORIGIN_Y: origin_y_r <= pwdata[COORD_BITS-1:0];
        REG_ORIGIN_Z: origin_z_r <= pwdata[COORD_BITS-1:0];
        REG_CELL_X:   cell_x_r   <= pwdata[CELL_W-1:0];
        REG_CELL_Y:   cell_y_r   <= pwdata[CELL_W-1:0];
        REG_CELL_Z:   cell_z_r   <= pwdata[CELL_W-1:0];
        REG_COUNTS:   counts_r   <= pwdata[COUNTS_W-1:0];
        default: ;    // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X: prdata = CFG_DATA_W'(origin_x_r);
      REG_ORIGIN_Y: prdata = CFG_DATA_W'(origin_y_r);
      REG_ORIGIN_Z: prdata = CFG_DATA_W'(origin_z_r);
      REG_CELL_X:   prdata = CFG_DATA_W'(cell_x_r);
      REG_CELL_Y:   prdata = CFG_DATA_W'(cell_y_r);
      REG_CELL_Z:   prdata = CFG_DATA_W'(cell_z_r);
      REG_COUNTS:   prdata = CFG_DATA_W'(counts_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // rdy[i]: stage i may load this cycle (it is empty or its successor moves).
  // rdy[NST] belongs to the output register.
  logic [NST:0]   rdy;
  logic [NST-1:0] en;
  logic [NST-1:0] v_r, v_nxt;
  logic [NST-1:0] func_r, func_nxt;
  logic           out_v_r, out_v_nxt;

  always_comb begin
    rdy[NST] = ~out_v_r | ~out_stall;
    for (int i = NST - 1; i >= 0; i--)
      rdy[i] = ~v_r[i] | rdy[i+1];
  end

  assign en       = rdy[NST-1:0];
  assign in_stall = ~rdy[0];

  always_comb begin
    v_nxt    = v_r;
    func_nxt = func_r;
    if (en[0]) begin
      v_nxt[0]    = in_valid;
      func_nxt[0] = in_func;
    end
    for (int i = 1; i < NST; i++) begin
      if (en[i]) begin
        v_nxt[i]    = v_r[i-1];
        func_nxt[i] = func_r[i-1];
      end
    end
    out_v_nxt = rdy[NST] ? v_r[NST-1] : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      v_r     <= v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) func_r <= func_nxt;

  assign out_valid = out_v_r;

  // ---------------- lanes ----------------
  logic                  ins_x, ins_y, ins_z;
  logic [INDEX_BITS-1:0] fnd_x, fnd_y, fnd_z;
  logic [COORD_BITS-1:0] ctr_x, ctr_y, ctr_z;

  vgpl_lane #(.INDEX_BITS(INDEX_BITS), .COORD_BITS(COORD_BITS)) u_lane_x (
    .clk     (clk),
    .en      (en),
    .point   (in_point_x),
    .index   (in_index_x),
    .origin  (origin_x_r),
    .cell_len(cell_x_r),
    .last    (counts_r[INDEX_BITS-1:0]),
    .in_range(ins_x),
    .found   (fnd_x),
    .center  (ctr_x)
  );

  vgpl_lane #(.INDEX_BITS(INDEX_BITS), .COORD_BITS(COORD_BITS)) u_lane_y (
    .clk     (clk),
    .en      (en),
    .point   (in_point_y),
    .index   (in_index_y),
    .origin  (origin_y_r),
    .cell_len(cell_y_r),
    .last    (counts_r[2*INDEX_BITS-1:INDEX_BITS]),
    .in_range(ins_y),
    .found   (fnd_y),
    .center  (ctr_y)
  );

  vgpl_lane #(.INDEX_BITS(INDEX_BITS), .COORD_BITS(COORD_BITS)) u_lane_z (
    .clk     (clk),
    .en      (en),
    .point   (in_point_z),
    .index   (in_index_z),
    .origin  (origin_z_r),
    .cell_len(cell_z_r),
    .last    (counts_r[3*INDEX_BITS-1:2*INDEX_BITS]),
    .in_range(ins_z),
    .found   (fnd_z),
    .center  (ctr_z)
  );

  // ---------------- merge / output register ----------------
  logic [COORD_BITS-1:0] res_ctr_x, res_ctr_y, res_ctr_z;

  vgpl_merge #(.INDEX_BITS(INDEX_BITS), .COORD_BITS(COORD_BITS)) u_merge (
    .clk       (clk),
    .load      (rdy[NST]),
    .func      (func_r[NST-1]),
    .inside_x  (ins_x),
    .inside_y  (ins_y),
    .inside_z  (ins_z),
    .found_x   (fnd_x),
    .found_y   (fnd_y),
    .found_z   (fnd_z),
    .center_x  (ctr_x),
    .center_y  (ctr_y),
    .center_z  (ctr_z),
    .inside_res(out_inside_res),
    .res_x     (out_found_x),
    .res_y     (out_found_y),
    .res_z     (out_found_z),
    .ctr_x     (res_ctr_x),
    .ctr_y     (res_ctr_y),
    .ctr_z     (res_ctr_z)
  );

  assign out_center_x = res_ctr_x;
  assign out_center_y = res_ctr_y;
  assign out_center_z = res_ctr_z;

endmodule

// ----- verif/grid_result_checker.sv -----
// Result checker for the voxel grid locator: tracks register writes, predicts and compares.
`timescale 1ns / 1ps

module grid_result_checker import vgpl_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_func,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  input  logic [INDEX_BITS-1:0]        in_index_x,
  input  logic [INDEX_BITS-1:0]        in_index_y,
  input  logic [INDEX_BITS-1:0]        in_index_z,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_inside_res,
  input  logic [INDEX_BITS-1:0]        out_found_x,
  input  logic [INDEX_BITS-1:0]        out_found_y,
  input  logic [INDEX_BITS-1:0]        out_found_z,
  input  logic signed [COORD_BITS-1:0] out_center_x,
  input  logic signed [COORD_BITS-1:0] out_center_y,
  input  logic signed [COORD_BITS-1:0] out_center_z,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           outstanding
);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-2:0]        cell_t;
  typedef logic [INDEX_BITS-1:0]        index_t;

  typedef struct packed {
    logic   in_grid;
    index_t found_x;
    index_t found_y;
    index_t found_z;
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
  } grid_result_t;

  localparam longint COORD_MAX_V = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN_V = -COORD_MAX_V - 1;

  // Shadow copy of the register file, x/y/z in slots 0/1/2.
  coord_t                      grid_origin [3];
  cell_t                       grid_cell_len [3];
  logic [3*INDEX_BITS-1:0]     grid_counts;

  grid_result_t expected_results [$];

  // One axis of a locate: inclusive range check, floor division, top edge clamped.
  function automatic logic locate_axis(input coord_t p, input coord_t org,
                                       input cell_t len, input index_t last,
                                       output index_t idx);
    longint off;
    longint extent;
    longint q;
    idx = '0;
    if (p < org) return 1'b0;
    off    = longint'(p) - longint'(org);
    extent = (longint'(last) + 1) * longint'(len);
    if (off > extent) return 1'b0;
    if (len == '0) return 1'b1;
    q = off / longint'(len);
    if (q > longint'(last)) q = longint'(last);
    idx = index_t'(q);
    return 1'b1;
  endfunction

  // Cell center, saturated to the coordinate range.
  function automatic coord_t center_axis(input coord_t org, input cell_t len,
                                         input index_t i);
    longint s;
    s = longint'(org) + longint'(i) * longint'(len) + longint'(len >> 1);
    if (s > COORD_MAX_V) s = COORD_MAX_V;
    if (s < COORD_MIN_V) s = COORD_MIN_V;
    return coord_t'(s);
  endfunction

  function automatic grid_result_t predict_grid_result(input logic fn,
                                                       input coord_t px, py, pz,
                                                       input index_t ix, iy, iz);
    grid_result_t r;
    coord_t       pt [3];
    index_t       hit [3];
    logic         ok;
    r  = '0;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    if (fn == FUNC_LOCATE) begin
      ok = 1'b1;
      for (int a = 0; a < 3; a++) begin
        ok &= locate_axis(pt[a], grid_origin[a], grid_cell_len[a],
                          grid_counts[a*INDEX_BITS +: INDEX_BITS], hit[a]);
      end
      if (ok) begin
        r.in_grid = 1'b1;
        r.found_x = hit[0];
        r.found_y = hit[1];
        r.found_z = hit[2];
      end
    end else begin
      r.center_x = center_axis(grid_origin[0], grid_cell_len[0], ix);
      r.center_y = center_axis(grid_origin[1], grid_cell_len[1], iy);
      r.center_z = center_axis(grid_origin[2], grid_cell_len[2], iz);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    grid_result_t want;
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        grid_origin[a]   = '0;
        grid_cell_len[a] = CELL_ONE[COORD_BITS-2:0];
      end
      grid_counts = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation pending");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("inside_res", longint'(want.in_grid), longint'(out_inside_res));
          check_field("found_x", longint'(want.found_x), longint'(out_found_x));
          check_field("found_y", longint'(want.found_y), longint'(out_found_y));
          check_field("found_z", longint'(want.found_z), longint'(out_found_z));
          check_field("center_x", longint'($signed(want.center_x)), longint'(out_center_x));
          check_field("center_y", longint'($signed(want.center_y)), longint'(out_center_y));
          check_field("center_z", longint'($signed(want.center_z)), longint'(out_center_z));
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_grid_result(in_func, in_point_x, in_point_y,
                                                       in_point_z, in_index_x, in_index_y,
                                                       in_index_z));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:REG_ADDR_LSB])
          REG_ORIGIN_X: grid_origin[0]   = coord_t'(pwdata[COORD_BITS-1:0]);
          REG_ORIGIN_Y: grid_origin[1]   = coord_t'(pwdata[COORD_BITS-1:0]);
          REG_ORIGIN_Z: grid_origin[2]   = coord_t'(pwdata[COORD_BITS-1:0]);
          REG_CELL_X:   grid_cell_len[0] = pwdata[COORD_BITS-2:0];
          REG_CELL_Y:   grid_cell_len[1] = pwdata[COORD_BITS-2:0];
          REG_CELL_Z:   grid_cell_len[2] = pwdata[COORD_BITS-2:0];
          REG_COUNTS:   grid_counts      = pwdata[3*INDEX_BITS-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top: clock, reset, stimulus and register programming for the voxel grid locator.
`timescale 1ns / 1ps

module tb_top;
  import vgpl_pkg::*;

  localparam int IB = INDEX_BITS_DEF;
  localparam int CB = COORD_BITS_DEF;

  // Address slot just past the register list; writes there must be dropped.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int QUIET_PHASE     = 2;   // no random idling, receiver hold-off
  localparam int PAUSE_PHASE     = 4;   // sender drains the pipe mid-phase
  localparam int HOLD_CYCLES     = 80;  // well past the pipe depth
  localparam int SETTLE_CYCLES   = 3 * (IB + 3);
  localparam int CYCLE_LIMIT     = 200000;

  localparam longint COORD_MAX_V = (longint'(1) <<< (CB - 1)) - 1;
  localparam longint COORD_MIN_V = -COORD_MAX_V - 1;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic [CB-2:0]        cell_t;
  typedef logic [IB-1:0]        index_t;

  // How a point coordinate is placed relative to one axis of the grid.
  typedef enum int {
    PT_INSIDE, PT_ORIGIN, PT_BELOW, PT_TOP, PT_ABOVE, PT_NOISE, PT_MIN, PT_MAX
  } point_kind_t;

  logic clk;
  logic rst_n;

  logic   in_valid, in_stall, in_func;
  coord_t in_point_x, in_point_y, in_point_z;
  index_t in_index_x, in_index_y, in_index_z;

  logic   out_valid, out_stall, out_inside_res;
  index_t out_found_x, out_found_y, out_found_z;
  coord_t out_center_x, out_center_y, out_center_z;

  logic                  psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  int fail_count;
  int outstanding;
  int cycle_cnt = 0;

  // Stimulus-side view of the grid, used only to aim points at edges and cells.
  coord_t grid_origin [3];
  cell_t  grid_cell_len [3];
  index_t grid_last [3];

  // Written by the stimulus process only, read by the result sink at clock edges.
  logic idle_on;
  logic hold_tgl;

  voxel_grid_point_locate u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_func,
    .in_point_x, .in_point_y, .in_point_z,
    .in_index_x, .in_index_y, .in_index_z,
    .out_valid, .out_stall, .out_inside_res,
    .out_found_x, .out_found_y, .out_found_z,
    .out_center_x, .out_center_y, .out_center_z,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  grid_result_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_func,
    .in_point_x, .in_point_y, .in_point_z,
    .in_index_x, .in_index_y, .in_index_z,
    .out_valid, .out_stall, .out_inside_res,
    .out_found_x, .out_found_y, .out_found_z,
    .out_center_x, .out_center_y, .out_center_z,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .outstanding
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Result sink: random stalls, a quiet stretch, and one long hold-off on request.
  // A flip of hold_tgl starts the hold-off; the count lives here.
  initial begin : result_sink
    int   hold_left;
    logic seen_tgl;
    hold_left = 0;
    seen_tgl  = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tgl != seen_tgl) begin
        seen_tgl  = hold_tgl;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 38);
      end
    end
  end

  function automatic coord_t clamp_coord(input longint v);
    if (v > COORD_MAX_V) return coord_t'(COORD_MAX_V);
    if (v < COORD_MIN_V) return coord_t'(COORD_MIN_V);
    return coord_t'(v);
  endfunction

  // Pick one coordinate on axis a according to kind k.
  function automatic coord_t axis_point(input int a, input point_kind_t k);
    longint org;
    longint len;
    longint top_v;
    longint off;
    org   = longint'(grid_origin[a]);
    len   = longint'(grid_cell_len[a]);
    top_v = org + (longint'(grid_last[a]) + 1) * len;
    case (k)
      PT_INSIDE: begin
        off = longint'($urandom_range(grid_last[a])) * len;
        if (len > 0) off += longint'($urandom_range(len - 1));
        return clamp_coord(org + off);
      end
      PT_ORIGIN: return grid_origin[a];
      PT_BELOW:  return clamp_coord(org - 1);
      PT_TOP:    return clamp_coord(top_v);
      PT_ABOVE:  return clamp_coord(top_v + 1);
      PT_MIN:    return coord_t'(COORD_MIN_V);
      PT_MAX:    return coord_t'(COORD_MAX_V);
      default:   return coord_t'($urandom);
    endcase
  endfunction

  // Center-mode index: mostly within the grid, sometimes anywhere in the field.
  function automatic index_t pick_index(input int a);
    if ($urandom_range(99) < 80) return index_t'($urandom_range(grid_last[a]));
    return index_t'($urandom);
  endfunction

  // One input transaction. Random idle cycles first, then hold valid and the
  // payload until the block takes it. Returns in the step of the accepting edge.
  task automatic send_item(input logic fn, input coord_t px, py, pz,
                           input index_t ix, iy, iz);
    while (idle_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= fn;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    in_index_x <= ix;
    in_index_y <= iy;
    in_index_z <= iz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Unused fields carry random bits; the block must ignore them.
  task automatic send_locate(input point_kind_t kx, ky, kz);
    send_item(FUNC_LOCATE, axis_point(0, kx), axis_point(1, ky), axis_point(2, kz),
              index_t'($urandom), index_t'($urandom), index_t'($urandom));
  endtask

  task automatic send_center(input index_t ix, iy, iz);
    send_item(FUNC_CENTER, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              ix, iy, iz);
  endtask

  // Stop offering and wait for every expected result. The checker's count
  // is registered, hence the first edge before looking at it.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Setup phase, then access phase; the write lands on the access edge.
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << REG_ADDR_LSB;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_grid();
    apb_write(REG_ORIGIN_X, CFG_DATA_W'($unsigned(grid_origin[0])));
    apb_write(REG_ORIGIN_Y, CFG_DATA_W'($unsigned(grid_origin[1])));
    apb_write(REG_ORIGIN_Z, CFG_DATA_W'($unsigned(grid_origin[2])));
    apb_write(REG_CELL_X, CFG_DATA_W'(grid_cell_len[0]));
    apb_write(REG_CELL_Y, CFG_DATA_W'(grid_cell_len[1]));
    apb_write(REG_CELL_Z, CFG_DATA_W'(grid_cell_len[2]));
    apb_write(REG_COUNTS, CFG_DATA_W'({grid_last[2], grid_last[1], grid_last[0]}));
  endtask

  // Mix of wide and narrow origins, cell sizes from one LSB to full range,
  // counts from a handful of cells up to the full index field.
  task automatic randomize_grid();
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(3))
        0:       grid_origin[a] = coord_t'($urandom);
        1:       grid_origin[a] = coord_t'(longint'($urandom_range(2097152)) - 1048576);
        2:       grid_origin[a] = '0;
        default: grid_origin[a] = coord_t'(-longint'($urandom_range(1 << 24)));
      endcase
      case ($urandom_range(3))
        0:       grid_cell_len[a] = cell_t'($urandom_range(262144, 1));
        1:       grid_cell_len[a] = cell_t'($urandom_range(255, 1));
        2:       grid_cell_len[a] = cell_t'($urandom);
        default: grid_cell_len[a] = cell_t'($urandom_range(16777216, 65536));
      endcase
      grid_last[a] = $urandom_range(1) ? index_t'($urandom_range(15)) : index_t'($urandom);
    end
  endtask

  // Directed sweep for the current grid: range edges on all axes together,
  // a miss on y alone and on z alone, the coordinate extremes, and centers at
  // the first cell, the last cell and the top of the index field.
  task automatic run_edges();
    send_locate(PT_ORIGIN, PT_ORIGIN, PT_ORIGIN);
    send_locate(PT_BELOW, PT_BELOW, PT_BELOW);
    send_locate(PT_TOP, PT_TOP, PT_TOP);
    send_locate(PT_ABOVE, PT_ABOVE, PT_ABOVE);
    send_locate(PT_ORIGIN, PT_ABOVE, PT_ORIGIN);
    send_locate(PT_ORIGIN, PT_ORIGIN, PT_BELOW);
    send_locate(PT_MIN, PT_MIN, PT_MIN);
    send_locate(PT_MAX, PT_MAX, PT_MAX);
    send_center('0, '0, '0);
    send_center(grid_last[0], grid_last[1], grid_last[2]);
    send_center('1, '1, '1);
  endtask

  // Random transaction: locates are mostly aimed into cells with a few edge
  // hits per axis, the rest raw noise over the full coordinate range; else a center.
  task automatic random_item();
    point_kind_t k [3];
    if ($urandom_range(99) < 55) begin
      for (int a = 0; a < 3; a++) begin
        if ($urandom_range(99) < 75) begin
          k[a] = ($urandom_range(99) < 80) ? PT_INSIDE
                                            : point_kind_t'($urandom_range(PT_ABOVE, PT_ORIGIN));
        end else begin
          k[a] = PT_NOISE;
        end
      end
      send_locate(k[0], k[1], k[2]);
    end else begin
      send_center(pick_index(0), pick_index(1), pick_index(2));
    end
  endtask

  initial begin : stimulus
    in_valid   = 1'b0;
    in_func    = FUNC_LOCATE;
    in_point_x = '0;
    in_point_y = '0;
    in_point_z = '0;
    in_index_x = '0;
    in_index_y = '0;
    in_index_z = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_on    = 1'b1;
    hold_tgl   = 1'b0;
    rst_n      = 1'b0;

    // Register values right after reset.
    for (int a = 0; a < 3; a++) begin
      grid_origin[a]   = '0;
      grid_cell_len[a] = CELL_ONE[CB-2:0];
      grid_last[a]     = '0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset: a single unit cell at the origin.
    send_locate(PT_ORIGIN, PT_ORIGIN, PT_ORIGIN);
    send_center('0, '0, '0);
    wait_drain();

    // Ordinary grid: negative and fractional origins, uneven cells, full z count.
    grid_origin[0]   = coord_t'(-327680);
    grid_origin[1]   = '0;
    grid_origin[2]   = coord_t'(688128);
    grid_cell_len[0] = cell_t'(98304);
    grid_cell_len[1] = cell_t'(16384);
    grid_cell_len[2] = cell_t'(131072);
    grid_last[0]     = index_t'(9);
    grid_last[1]     = index_t'(99);
    grid_last[2]     = '1;
    program_grid();
    run_edges();
    wait_drain();

    // Extremes: origins at both ends of the range, the largest and smallest
    // cells, a zero-length cell on z, all counts at maximum. Some centers on x
    // and y saturate; z only holds the point equal to its origin.
    grid_origin[0]   = coord_t'(COORD_MIN_V);
    grid_origin[1]   = coord_t'(COORD_MAX_V);
    grid_origin[2]   = '0;
    grid_cell_len[0] = '1;
    grid_cell_len[1] = cell_t'(1);
    grid_cell_len[2] = '0;
    grid_last[0]     = '1;
    grid_last[1]     = '1;
    grid_last[2]     = '1;
    program_grid();
    apb_write(REG_UNUSED, {$urandom, $urandom});
    run_edges();
    wait_drain();

    // Random grids. One phase runs without idling and with a long receiver
    // hold-off so the pipe backs up into in_stall; another drains mid-phase.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      randomize_grid();
      program_grid();
      idle_on <= (ph != QUIET_PHASE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == QUIET_PHASE && n == 40) hold_tgl <= ~hold_tgl;
        if (ph == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) wait_drain();
        random_item();
      end
      wait_drain();
    end

    // Give a stray late transaction time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
